// ===== hdl/bfq_pkg.sv =====
// Package for the half-precision to block fixed-point quantizer.
// Field widths, constants and the per-word quantize function.
// No dependencies.
`timescale 1ns / 1ps

package bfq_pkg;

	localparam int unsigned BLOCK_DEPTH_DEF = 64;

	localparam int unsigned HALF_W  = 16;
	localparam int unsigned EXP_W   = 5;
	localparam int unsigned FIXED_W = 8;

	localparam logic [15:0] EXP_MASK   = 16'h7c00;
	localparam logic [15:0] MANT_MASK  = 16'h03ff;
	localparam logic [15:0] HIDDEN_ONE = 16'h0400;
	localparam logic [15:0] SIGN_MASK  = 16'h8000;
	localparam logic [8:0]  ROUND_MASK = 9'h1fc;

	// Shift of (diff + 2) reaches 11 when diff reaches this
	localparam logic [EXP_W-1:0] DIFF_ZERO = 5'd9;

	function automatic int unsigned idx_width(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic logic [FIXED_W-1:0] quantize(input logic [HALF_W-1:0] word,
			input logic [EXP_W-1:0] blk_exp);
		logic            neg;
		logic [EXP_W-1:0] e;
		logic [EXP_W-1:0] diff;
		logic [10:0]     mant;
		logic [10:0]     sh;
		logic [8:0]      v;
		logic [9:0]      r;
		logic [6:0]      mag;
		neg  = (word & SIGN_MASK) != 16'h0;
		e    = EXP_W'((word & EXP_MASK) >> 10);
		mant = 11'((word & MANT_MASK) | HIDDEN_ONE);
		diff = blk_exp - e;
		sh   = mant >> (diff + 5'd2);
		v    = (diff >= DIFF_ZERO) ? 9'd0 : sh[8:0];
		r    = {1'b0, v};
		if ((v & ROUND_MASK) != ROUND_MASK)
			r = {1'b0, v} + {9'd0, v[2]} + 10'd1;
		mag = r[8:2];
		return neg ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
	endfunction

endpackage

// ===== hdl/bfq_if.sv =====
// Stream interfaces for the quantizer: incoming half words and outgoing results.
// Depends on bfq_pkg.
`timescale 1ns / 1ps

interface bfq_word_if import bfq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] half_word;
	logic              block_end;

	modport source(output valid, half_word, block_end, input ready);
	modport sink(input valid, half_word, block_end, output ready);
endinterface

interface bfq_result_if import bfq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FIXED_W-1:0] fixed_value;
	logic [EXP_W-1:0]          block_exponent;
	logic                      final_result;

	modport source(output valid, fixed_value, block_exponent, final_result, input ready);
	modport sink(input valid, fixed_value, block_exponent, final_result, output ready);
endinterface

// ===== hdl/bfq_desc_fifo.sv =====
// Two-entry queue of closed-block descriptors between the front and back ends.
// No package dependencies.
`timescale 1ns / 1ps

module bfq_desc_fifo #(
	parameter int unsigned W = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign empty    = (cnt_q == 2'd0);
	assign full     = (cnt_q == 2'd2);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hdl/bfq_front.sv =====
// Front end: takes half words, writes them to the buffer bank being filled,
// tracks the block's largest exponent and closes blocks. Depends on bfq_pkg, bfq_if.
`timescale 1ns / 1ps

module bfq_front import bfq_pkg::*; #(
	parameter int unsigned BLOCK_DEPTH = BLOCK_DEPTH_DEF,
	localparam int unsigned AW = idx_width(BLOCK_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bfq_word_if.sink             word_ch,
	input  logic                 done,
	input  logic                 fifo_full,
	output logic                 wr_en,
	output logic [AW:0]          wr_addr,
	output logic [HALF_W-1:0]    wr_data,
	output logic                 push,
	output logic [AW+EXP_W-1:0]  push_data
);

	logic [AW-1:0]    fill_q;
	logic [EXP_W-1:0] max_q;
	logic             wbank_q;
	logic [1:0]       credit_q;
	logic             xfer;
	logic             close;
	logic [EXP_W-1:0] e;
	logic [EXP_W-1:0] new_max;

	// At most two blocks (one per bank) wait for or are in readout
	assign word_ch.ready = (credit_q != 2'd2) && !fifo_full;
	assign xfer          = word_ch.valid && word_ch.ready;
	assign e             = word_ch.half_word[14:10];
	assign new_max       = (e > max_q) ? e : max_q;
	assign close         = word_ch.block_end || (fill_q == AW'(BLOCK_DEPTH - 1));

	assign wr_en     = xfer;
	assign wr_addr   = {wbank_q, fill_q};
	assign wr_data   = word_ch.half_word;
	assign push      = xfer && close;
	assign push_data = {fill_q, new_max};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			max_q    <= '0;
			wbank_q  <= 1'b0;
			credit_q <= 2'd0;
		end else begin
			if (xfer) begin
				if (close) begin
					fill_q  <= '0;
					max_q   <= '0;
					wbank_q <= ~wbank_q;
				end else begin
					fill_q <= fill_q + 1'b1;
					max_q  <= new_max;
				end
			end
			credit_q <= credit_q + {1'b0, push} - {1'b0, done};
		end
	end

endmodule

// ===== hdl/bfq_back.sv =====
// Back end: holds the two-bank word buffer and reads a closed block out, one quantized
// result per unstalled cycle into the output register. Depends on bfq_pkg, bfq_if.
`timescale 1ns / 1ps

module bfq_back import bfq_pkg::*; #(
	parameter int unsigned BLOCK_DEPTH = BLOCK_DEPTH_DEF,
	localparam int unsigned AW = idx_width(BLOCK_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [AW:0]         wr_addr,
	input  logic [HALF_W-1:0]   wr_data,
	input  logic                fifo_empty,
	input  logic [AW+EXP_W-1:0] pop_data,
	output logic                pop,
	output logic                done,
	bfq_result_if.source        result_ch
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	logic [HALF_W-1:0] mem [2**(AW+1)];

	state_t            state_q;
	logic              rbank_q;
	logic [AW-1:0]     k_q;
	logic [AW-1:0]     last_q;
	logic [EXP_W-1:0]  exp_q;
	logic [HALF_W-1:0] rdata_q;
	logic              out_valid_q;
	logic [FIXED_W-1:0] fixed_q;
	logic [EXP_W-1:0]  bexp_q;
	logic              final_q;

	logic              load;
	logic              rd_en;
	logic [AW:0]       rd_addr;
	logic              at_last;

	assign load    = (state_q == ST_EMIT) && (!out_valid_q || result_ch.ready);
	assign at_last = (k_q == last_q);
	assign pop     = (state_q == ST_IDLE) && !fifo_empty;
	assign done    = load && at_last;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {rbank_q, k_q};
		if (pop) begin
			rd_en   = 1'b1;
			rd_addr = {rbank_q, {AW{1'b0}}};
		end else if (load && !at_last) begin
			rd_en   = 1'b1;
			rd_addr = {rbank_q, k_q + 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rbank_q     <= 1'b0;
			k_q         <= '0;
			last_q      <= '0;
			exp_q       <= '0;
			out_valid_q <= 1'b0;
			fixed_q     <= '0;
			bexp_q      <= '0;
			final_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				fixed_q     <= quantize(rdata_q, exp_q);
				bexp_q      <= exp_q;
				final_q     <= at_last;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						k_q     <= '0;
						last_q  <= pop_data[AW+EXP_W-1:EXP_W];
						exp_q   <= pop_data[EXP_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (at_last) begin
							rbank_q <= ~rbank_q;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.fixed_value    = fixed_q;
	assign result_ch.block_exponent = bexp_q;
	assign result_ch.final_result   = final_q;

endmodule

// ===== hdl/half_to_block_fixed_quantizer.sv =====
// Top level of the half-precision to block fixed-point quantizer.
// Depends on bfq_pkg, bfq_if, bfq_front, bfq_desc_fifo and bfq_back.
`timescale 1ns / 1ps

// Words are taken one per cycle and written to one bank of a two-bank word
// buffer while the largest exponent is tracked. A block closes on block_end or
// when BLOCK_DEPTH words are held; it is then queued for readout and the front
// keeps filling the other bank. Readout begins once the block is dequeued, with
// its first word read from the buffer as the descriptor is popped, and gives one
// result per cycle while the sink takes them, paced by the buffer's single read
// port. The front stalls only while both banks hold blocks that have not been
// fully read out.

module half_to_block_fixed_quantizer import bfq_pkg::*; #(
	parameter int unsigned BLOCK_DEPTH = BLOCK_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	bfq_word_if.sink     word_ch,
	bfq_result_if.source result_ch
);

	localparam int unsigned AW = idx_width(BLOCK_DEPTH);

	logic                wr_en;
	logic [AW:0]         wr_addr;
	logic [HALF_W-1:0]   wr_data;
	logic                push;
	logic [AW+EXP_W-1:0] push_data;
	logic                pop;
	logic [AW+EXP_W-1:0] pop_data;
	logic                fifo_empty;
	logic                fifo_full;
	logic                done;

	bfq_front #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_ch   (word_ch),
		.done      (done),
		.fifo_full (fifo_full),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.push_data (push_data)
	);

	bfq_desc_fifo #(.W(AW + EXP_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	bfq_back #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.fifo_empty (fifo_empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.done       (done),
		.result_ch  (result_ch)
	);

endmodule

// ===== hdl/bfq_checker.sv =====
// Port-level checks for the quantizer, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module bfq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       word_valid,
	input logic       word_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] fixed_value,
	input logic [4:0] block_exponent,
	input logic       final_result
);

	logic       word_xfer;
	logic       res_xfer;
	logic [8:0] pending_q;
	logic       mid_q;
	logic [4:0] exp_q;

	assign word_xfer = word_valid && word_ready;
	assign res_xfer  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			mid_q     <= 1'b0;
			exp_q     <= '0;
		end else begin
			pending_q <= pending_q + {8'd0, word_xfer} - {8'd0, res_xfer};
			if (res_xfer) begin
				mid_q <= !final_result;
				exp_q <= block_exponent;
			end
		end
	end

	// A result is never delivered for a word that was not taken
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer |-> pending_q != 9'd0)
		else $error("result transfer without a pending word");

	// All results of one block carry the same block exponent
	a_exp_steady: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && mid_q |-> block_exponent == exp_q)
		else $error("block exponent changed inside a block");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> fixed_value != 8'h80)
		else $error("fixed value out of range");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(fixed_value)
			&& $stable(block_exponent) && $stable(final_result))
		else $error("stalled result changed");

endmodule

bind half_to_block_fixed_quantizer bfq_checker u_bfq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.word_valid     (word_ch.valid),
	.word_ready     (word_ch.ready),
	.res_valid      (result_ch.valid),
	.res_ready      (result_ch.ready),
	.fixed_value    (result_ch.fixed_value),
	.block_exponent (result_ch.block_exponent),
	.final_result   (result_ch.final_result)
);

// ===== dv/half_to_block_fixed_quantizer_tb.sv =====
// Testbench for half_to_block_fixed_quantizer: drives blocks of half words and
// checks every aligned 8-bit result against a predictor kept in the bench.
// Depends on bfq_pkg, bfq_if and the quantizer RTL.
`timescale 1ns / 1ps

module half_to_block_fixed_quantizer_tb;
	import bfq_pkg::*;

	localparam int unsigned DEPTH = BLOCK_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 40000;
	localparam int unsigned REPORT_MAX = 10;
	localparam int unsigned TAIL_CYCLES = 16;

	typedef struct packed {
		logic signed [FIXED_W-1:0] fixed_value;
		logic [EXP_W-1:0]          block_exponent;
		logic                      final_result;
	} quant_result_t;

	logic clk;
	logic arst_n;

	bfq_word_if   word_ch();
	bfq_result_if result_ch();

	half_to_block_fixed_quantizer #(.BLOCK_DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.word_ch  (word_ch),
		.result_ch(result_ch)
	);

	quant_result_t     expected_results[$];
	logic [HALF_W-1:0] block_words[$];
	logic [EXP_W-1:0]  block_max_exp;

	bit          calm;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned words_sent;
	int unsigned blocks_closed;
	int unsigned results_checked;
	int unsigned stall_left;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Align one stored word to the block exponent and round to 8 signed bits
	function automatic logic signed [FIXED_W-1:0] align_to_block(input logic [HALF_W-1:0] w,
			input logic [EXP_W-1:0] blk_exp);
		logic [EXP_W-1:0]   diff;
		logic [10:0]        mant;
		int unsigned        shift;
		int unsigned        mag;
		logic [FIXED_W-1:0] res;
		diff  = blk_exp - w[14:10];
		mant  = {1'b1, w[9:0]};
		shift = diff + 2;
		mag   = (shift >= 11) ? 0 : (mant >> shift);
		if ((mag & ROUND_MASK) != ROUND_MASK)
			mag = mag + ((mag >> 2) & 1) + 1;
		mag = mag >> 2;
		res = mag[FIXED_W-1:0];
		if (w[15])
			res = 8'd0 - res;
		return res;
	endfunction

	// Buffer an accepted word; on block close, queue one result per buffered word
	task automatic record_word(input logic [HALF_W-1:0] w, input logic last);
		quant_result_t r;
		block_words.push_back(w);
		if (w[14:10] > block_max_exp)
			block_max_exp = w[14:10];
		if (last || block_words.size() == DEPTH) begin
			foreach (block_words[k]) begin
				r.fixed_value    = align_to_block(block_words[k], block_max_exp);
				r.block_exponent = block_max_exp;
				r.final_result   = (k == block_words.size() - 1);
				expected_results.push_back(r);
			end
			block_words.delete();
			block_max_exp = '0;
			blocks_closed++;
		end
	endtask

	task automatic send_word(input logic [HALF_W-1:0] w, input logic last);
		int unsigned gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			word_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		word_ch.valid     <= 1'b1;
		word_ch.half_word <= w;
		word_ch.block_end <= last;
		do @(posedge clk); while (!word_ch.ready);
		record_word(w, last);
		words_sent++;
	endtask

	// Hold off the sender until every queued result has been taken
	task automatic wait_drained();
		@(negedge clk);
		word_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [HALF_W-1:0] make_word(input logic [EXP_W-1:0] base, input bit near);
		int unsigned drop;
		logic [EXP_W-1:0] e;
		drop = $urandom_range(0, 11);
		e = near ? ((base > drop) ? EXP_W'(base - drop) : 5'd0)
			: EXP_W'($urandom_range(0, 31));
		return {1'($urandom_range(0, 1)), e, 10'($urandom_range(0, 1023))};
	endfunction

	// Mostly exponents clustered under a block base, with some fully random words
	task automatic send_block(input int unsigned n);
		logic [EXP_W-1:0] base;
		base = EXP_W'($urandom_range(0, 31));
		for (int unsigned i = 0; i < n; i++)
			send_word(make_word(base, $urandom_range(0, 3) != 0), i == n - 1);
	endtask

	task automatic test_special_words();
		send_word(16'h0000, 1'b1);
		send_word(16'hffff, 1'b1);
		send_word(16'h7fff, 1'b1);
		send_word(16'h8000, 1'b1);
		send_word(16'h7c00, 1'b1);
		send_word(16'h7e00, 1'b1);
		send_word(16'h03ff, 1'b1);
	endtask

	// Walk the exponent gap from 0 to 11; the widest gaps flush to zero,
	// and a set sign there still gives zero
	task automatic test_shift_range();
		send_word(16'h7800, 1'b0);
		for (int unsigned d = 1; d <= 11; d++)
			send_word({1'(d[0]), 5'(30 - d), 10'($urandom_range(0, 1023))}, d == 11);
	endtask

	task automatic test_rounding_edge();
		send_word(16'h7bff, 1'b0);
		send_word(16'hfbff, 1'b0);
		send_word(16'h7bec, 1'b0);
		send_word(16'h7a00, 1'b1);
	endtask

	// No block_end: the block must close when the buffer fills
	task automatic test_full_block();
		logic [EXP_W-1:0] base;
		base = EXP_W'($urandom_range(0, 31));
		for (int unsigned i = 0; i < DEPTH; i++)
			send_word(make_word(base, $urandom_range(0, 3) != 0), 1'b0);
	endtask

	task automatic test_random_blocks(input int unsigned budget);
		int unsigned n;
		while (budget > 0) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			if (n > budget)
				n = budget;
			send_block(n);
			budget -= n;
		end
	endtask

	task automatic test_calm_tail();
		calm = 1'b1;
		test_random_blocks(20);
	endtask

	// Result sink: random stall bursts while not calm
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 4) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		quant_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result: fixed %0d exp %0d final %0b",
						result_ch.fixed_value, result_ch.block_exponent,
						result_ch.final_result);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result_ch.fixed_value !== want.fixed_value
						|| result_ch.block_exponent !== want.block_exponent
						|| result_ch.final_result !== want.final_result) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("result %0d mismatch: expected fixed %0d exp %0d final %0b, got fixed %0d exp %0d final %0b",
							results_checked, want.fixed_value, want.block_exponent,
							want.final_result, result_ch.fixed_value,
							result_ch.block_exponent, result_ch.final_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("half_to_block_fixed_quantizer verification failed");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		word_ch.valid     = 1'b0;
		word_ch.half_word = '0;
		word_ch.block_end = 1'b0;
		block_max_exp     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_special_words();
		test_shift_range();
		test_rounding_edge();
		wait_drained();
		test_full_block();
		wait_drained();
		test_random_blocks(45);
		test_calm_tail();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d half words in %0d blocks, checked %0d aligned results.",
			words_sent, blocks_closed, results_checked);
		$display("Covered special encodings, full exponent gap range, rounding edge and full buffer.");
		if (mismatch_count == 0)
			$display("half_to_block_fixed_quantizer verification clean");
		else
			$display("half_to_block_fixed_quantizer verification failed");
		$finish;
	end

endmodule
